[sv/cfa_pkg.sv]
`default_nettype none

package cfa_pkg;

  // payload widths
  localparam int FRAME_W = 20;
  localparam int CNT_W = 11;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 20;

  typedef logic [1:0] op_t;
  typedef logic [1:0] status_t;
  typedef logic [1:0] fstate_t;
  typedef logic [FRAME_W-1:0] frame_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  // operations
  localparam op_t OP_ALLOC = 2'd0;
  localparam op_t OP_RELEASE = 2'd1;
  localparam op_t OP_MARK = 2'd2;

  // result status
  localparam status_t RS_OK = 2'd0;
  localparam status_t RS_NO_RUN = 2'd1;
  localparam status_t RS_NOT_HEAD = 2'd2;
  localparam status_t RS_BAD = 2'd3;

  // per-frame map codes
  localparam fstate_t FS_FREE = 2'b00;
  localparam fstate_t FS_USED = 2'b01;
  localparam fstate_t FS_HEAD = 2'b11;

  // register indexes
  localparam cfg_idx_t CFG_POOL_BASE = 2'd0;
  localparam cfg_idx_t CFG_POOL_FRAMES = 2'd1;
  localparam cfg_idx_t CFG_RESERVE_FIRST = 2'd2;

  localparam cnt_t RESET_FRAMES = 11'd1024;
  localparam int CNT_MAX = 2047;

endpackage

`default_nettype wire

[sv/cfa_if.sv]
`default_nettype none

interface cfa_req_if;
  import cfa_pkg::*;
  logic valid;
  logic ready;
  op_t op;
  frame_t frame_no;
  cnt_t count;
  modport source (output valid, output op, output frame_no, output count, input ready);
  modport sink (input valid, input op, input frame_no, input count, output ready);
endinterface

interface cfa_rsp_if;
  import cfa_pkg::*;
  logic valid;
  logic ready;
  status_t status;
  frame_t first_frame;
  cnt_t freed_count;
  modport source (output valid, output status, output first_frame, output freed_count,
                  input ready);
  modport sink (input valid, input status, input first_frame, input freed_count,
                output ready);
endinterface

interface cfa_cfg_if;
  import cfa_pkg::*;
  logic valid;
  logic ready;
  cfg_idx_t index;
  cfg_data_t data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[sv/contiguous_frame_allocator_unit.sv]
`default_nettype none
// sequence: decode (S_DEC, S_CHK), then allocate scans the map one frame a cycle
//   and writes the run one frame a cycle, release walks head and used frames, and mark
//   writes its run; the result then moves from S_RESP to the response register once it is free
// throughput: one request at a time, set by the single read and single write port of the map
// reset (and any write to a defined register): clearing pass over all MAX_FRAMES map entries, no requests
//   taken meanwhile; at reset registers return to base 0, 1024 frames, no reserved frame

module contiguous_frame_allocator_unit #(
  parameter int MAX_FRAMES = 1024
) (
  input  wire logic clk,
  input  wire logic rst,
  cfa_cfg_if.sink   cfg,
  cfa_req_if.sink   req,
  cfa_rsp_if.source rsp
);
  import cfa_pkg::*;

  localparam int AW = $clog2(MAX_FRAMES);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_FRAMES - 1);
  // largest pool the map and the 11-bit count can both hold
  localparam int CAP = (MAX_FRAMES < CNT_MAX) ? MAX_FRAMES : CNT_MAX;
  localparam cnt_t CAP_N = CNT_W'(CAP);
  localparam cnt_t RESET_N = (CAP_N < RESET_FRAMES) ? CAP_N : RESET_FRAMES;

  // sequencer states
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DEC   = 3'd2;
  localparam logic [2:0] S_CHK   = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_MARK  = 3'd5;
  localparam logic [2:0] S_REL   = 3'd6;
  localparam logic [2:0] S_RESP  = 3'd7;

  // frame map, one read and one write port
  fstate_t frame_map [MAX_FRAMES];

  // control state
  logic [2:0] state, state_next;
  logic [AW-1:0] clr_ptr, clr_ptr_next;
  logic rd_vld, rd_vld_next;
  logic ov, ov_next;
  frame_t pool_base, pool_base_next;
  cnt_t pool_frames, pool_frames_next;
  logic reserve_first, reserve_first_next;
  cnt_t free_count, free_count_next;

  // working registers
  op_t op_q, op_q_next;
  frame_t fno_q, fno_q_next;
  cnt_t cnt_q, cnt_q_next;
  logic [FRAME_W:0] rel_q, rel_q_next;    // top bit is the borrow of frame_no - base
  cnt_t ptr, ptr_next;                    // next map entry to read
  cnt_t rd_idx, rd_idx_next;              // entry whose data sits in rd_data
  fstate_t rd_data;
  cnt_t run, run_next;
  cnt_t head, head_next;
  cnt_t last, last_next;
  cnt_t freed, freed_next;
  status_t res_status, res_status_next;
  frame_t res_first, res_first_next;
  cnt_t res_freed, res_freed_next;
  status_t out_status;
  frame_t out_first;
  cnt_t out_freed;

  // map port controls
  logic re, we;
  logic [AW-1:0] ra, wa;
  fstate_t wd;

  cnt_t n_pool;

  // effective pool size
  assign n_pool = (pool_frames < CAP_N) ? pool_frames : CAP_N;

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign rsp.valid = ov;
  assign rsp.status = out_status;
  assign rsp.first_frame = out_first;
  assign rsp.freed_count = out_freed;

  always_comb begin
    cnt_t v_head;
    cnt_t v_freed;
    cnt_t v_npf;
    cnt_t v_nn;
    logic v_nrf;
    logic v_done;

    state_next = state;
    clr_ptr_next = clr_ptr;
    rd_vld_next = 1'b0;
    ov_next = ov && !rsp.ready;
    pool_base_next = pool_base;
    pool_frames_next = pool_frames;
    reserve_first_next = reserve_first;
    free_count_next = free_count;
    op_q_next = op_q;
    fno_q_next = fno_q;
    cnt_q_next = cnt_q;
    rel_q_next = rel_q;
    ptr_next = ptr;
    rd_idx_next = rd_idx;
    run_next = run;
    head_next = head;
    last_next = last;
    freed_next = freed;
    res_status_next = res_status;
    res_first_next = res_first;
    res_freed_next = res_freed;
    re = 1'b0;
    ra = AW'(ptr);
    we = 1'b0;
    wa = AW'(rd_idx);
    wd = FS_FREE;
    v_head = head;
    v_freed = freed;
    v_npf = pool_frames;
    v_nn = n_pool;
    v_nrf = reserve_first;
    v_done = 1'b0;

    unique case (state)
      S_CLEAR: begin
        // sweep the whole map; frame 0 held used when reserved
        we = 1'b1;
        wa = clr_ptr;
        wd = (clr_ptr == '0 && reserve_first && n_pool != '0) ? FS_USED : FS_FREE;
        if (clr_ptr == LAST_ADDR) begin
          state_next = S_IDLE;
        end else begin
          clr_ptr_next = clr_ptr + AW'(1);
        end
      end

      S_IDLE: begin
        if (req.valid) begin
          op_q_next = req.op;
          fno_q_next = req.frame_no;
          cnt_q_next = req.count;
          state_next = S_DEC;
        end
      end

      S_DEC: begin
        rel_q_next = {1'b0, fno_q} - {1'b0, pool_base};
        state_next = S_CHK;
      end

      S_CHK: begin
        res_status_next = RS_BAD;
        res_first_next = '0;
        res_freed_next = '0;
        state_next = S_RESP;
        unique case (op_q)
          OP_ALLOC: begin
            if (cnt_q == '0) begin
              res_status_next = RS_BAD;
            end else if (n_pool == '0) begin
              res_status_next = RS_NO_RUN;
            end else begin
              ptr_next = '0;
              run_next = '0;
              state_next = S_SCAN;
            end
          end
          OP_RELEASE: begin
            if (!rel_q[FRAME_W] &&
                rel_q[FRAME_W-1:0] < {{(FRAME_W-CNT_W){1'b0}}, n_pool}) begin
              head_next = rel_q[CNT_W-1:0];
              ptr_next = rel_q[CNT_W-1:0];
              freed_next = '0;
              state_next = S_REL;
            end
          end
          OP_MARK: begin
            if (cnt_q != '0 && !rel_q[FRAME_W] &&
                rel_q[FRAME_W-1:0] < {{(FRAME_W-CNT_W){1'b0}}, n_pool} &&
                cnt_q <= n_pool - rel_q[CNT_W-1:0]) begin
              head_next = rel_q[CNT_W-1:0];
              last_next = rel_q[CNT_W-1:0] + cnt_q - CNT_W'(1);
              ptr_next = rel_q[CNT_W-1:0];
              state_next = S_MARK;
            end
          end
          default: begin
            res_status_next = RS_BAD;
          end
        endcase
      end

      S_SCAN: begin
        // first fit: read one entry a cycle, count free frames in a row
        if (ptr < n_pool) begin
          re = 1'b1;
          ra = AW'(ptr);
          rd_idx_next = ptr;
          ptr_next = ptr + CNT_W'(1);
          rd_vld_next = 1'b1;
        end
        if (rd_vld) begin
          if (rd_data != FS_FREE) begin
            run_next = '0;
          end else begin
            run_next = run + CNT_W'(1);
          end
          if (rd_data == FS_FREE && run + CNT_W'(1) == cnt_q) begin
            v_head = rd_idx + CNT_W'(1) - cnt_q;
            head_next = v_head;
            last_next = rd_idx;
            ptr_next = v_head;
            rd_vld_next = 1'b0;
            state_next = S_MARK;
          end else if (rd_idx == n_pool - CNT_W'(1)) begin
            res_status_next = RS_NO_RUN;
            res_first_next = '0;
            res_freed_next = '0;
            rd_vld_next = 1'b0;
            state_next = S_RESP;
          end
        end
      end

      S_MARK: begin
        // read ahead one entry, write back the one read last cycle
        if (ptr <= last) begin
          re = 1'b1;
          ra = AW'(ptr);
          rd_idx_next = ptr;
          ptr_next = ptr + CNT_W'(1);
          rd_vld_next = 1'b1;
        end
        if (rd_vld) begin
          we = 1'b1;
          wa = AW'(rd_idx);
          wd = (rd_idx == head) ? FS_HEAD : FS_USED;
          if (rd_data == FS_FREE && free_count != '0) begin
            free_count_next = free_count - CNT_W'(1);
          end
          if (rd_idx == last) begin
            res_status_next = RS_OK;
            res_first_next = (op_q == OP_ALLOC) ?
                             pool_base + {{(FRAME_W-CNT_W){1'b0}}, head} : '0;
            res_freed_next = '0;
            rd_vld_next = 1'b0;
            state_next = S_RESP;
          end
        end
      end

      S_REL: begin
        if (ptr < n_pool) begin
          re = 1'b1;
          ra = AW'(ptr);
          rd_idx_next = ptr;
          ptr_next = ptr + CNT_W'(1);
          rd_vld_next = 1'b1;
        end
        if (rd_vld) begin
          if (rd_idx == head) begin
            if (rd_data != FS_HEAD) begin
              res_status_next = RS_NOT_HEAD;
              res_first_next = '0;
              res_freed_next = '0;
              rd_vld_next = 1'b0;
              state_next = S_RESP;
            end else begin
              we = 1'b1;
              v_freed = CNT_W'(1);
              v_done = (rd_idx == n_pool - CNT_W'(1));
            end
          end else if (rd_data == FS_USED) begin
            we = 1'b1;
            v_freed = freed + CNT_W'(1);
            v_done = (rd_idx == n_pool - CNT_W'(1));
          end else begin
            // run ends at the first frame that is not used
            v_done = 1'b1;
          end
          wa = AW'(rd_idx);
          wd = FS_FREE;
          freed_next = v_freed;
          if (v_done) begin
            free_count_next = free_count + v_freed;
            res_status_next = RS_OK;
            res_first_next = '0;
            res_freed_next = v_freed;
            rd_vld_next = 1'b0;
            state_next = S_RESP;
          end
        end
      end

      S_RESP: begin
        // hand the result over once the response register is free
        if (!ov || rsp.ready) begin
          ov_next = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_CLEAR;
      end
    endcase

    // write to a defined register: new value and a fresh map
    if (cfg.valid) begin
      case (cfg.index)
        CFG_POOL_BASE: begin
          pool_base_next = cfg.data[FRAME_W-1:0];
        end
        CFG_POOL_FRAMES: begin
          pool_frames_next = cfg.data[CNT_W-1:0];
          v_npf = cfg.data[CNT_W-1:0];
        end
        CFG_RESERVE_FIRST: begin
          reserve_first_next = cfg.data[0];
          v_nrf = cfg.data[0];
        end
        default: begin
        end
      endcase
      if (cfg.index == CFG_POOL_BASE || cfg.index == CFG_POOL_FRAMES ||
          cfg.index == CFG_RESERVE_FIRST) begin
        v_nn = (v_npf < CAP_N) ? v_npf : CAP_N;
        free_count_next = (v_nrf && v_nn != '0) ? v_nn - CNT_W'(1) : v_nn;
        clr_ptr_next = '0;
        rd_vld_next = 1'b0;
        state_next = S_CLEAR;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_ptr <= '0;
      rd_vld <= 1'b0;
      ov <= 1'b0;
      pool_base <= '0;
      pool_frames <= RESET_FRAMES;
      reserve_first <= 1'b0;
      free_count <= RESET_N;
    end else begin
      state <= state_next;
      clr_ptr <= clr_ptr_next;
      rd_vld <= rd_vld_next;
      ov <= ov_next;
      pool_base <= pool_base_next;
      pool_frames <= pool_frames_next;
      reserve_first <= reserve_first_next;
      free_count <= free_count_next;
    end
  end

  // working and result payload, no reset
  always_ff @(posedge clk) begin
    op_q <= op_q_next;
    fno_q <= fno_q_next;
    cnt_q <= cnt_q_next;
    rel_q <= rel_q_next;
    ptr <= ptr_next;
    rd_idx <= rd_idx_next;
    run <= run_next;
    head <= head_next;
    last <= last_next;
    freed <= freed_next;
    res_status <= res_status_next;
    res_first <= res_first_next;
    res_freed <= res_freed_next;
    if (state == S_RESP && (!ov || rsp.ready)) begin
      out_status <= res_status;
      out_first <= res_first;
      out_freed <= res_freed;
    end
  end

  // frame map
  always_ff @(posedge clk) begin
    if (we) begin
      frame_map[wa] <= wd;
    end
    if (re) begin
      rd_data <= frame_map[ra];
    end
  end

  // no request taken during the clearing pass
  assert property (@(posedge clk) disable iff (rst) state == S_CLEAR |-> !req.ready)
    else $error("request ready during map clear");

  // a map read in flight always points inside the pool
  assert property (@(posedge clk) disable iff (rst) rd_vld |-> rd_idx < n_pool)
    else $error("map read outside the pool");

  // free frames never exceed the pool
  assert property (@(posedge clk) disable iff (rst) free_count <= n_pool)
    else $error("free count above pool size");

  // a response appears only from the response state
  assert property (@(posedge clk) disable iff (rst)
                   $rose(rsp.valid) |-> $past(state) == S_RESP)
    else $error("response without a finished request");

endmodule

`default_nettype wire

[sim/contiguous_frame_allocator_unit_tb.sv]
`default_nettype none

module contiguous_frame_allocator_unit_tb;
  import cfa_pkg::*;

  // map depth of the instance under test
  localparam int POOL_CAP = 1024;

  // codes the package leaves unnamed
  localparam op_t OP_UNDEF = 2'd3;
  localparam cfg_idx_t CFG_UNUSED = 2'd3;

  // one reply of the allocator, as seen on the response channel
  typedef struct packed {
    status_t status;
    frame_t first_frame;
    cnt_t freed_count;
  } alloc_reply_t;

  // tracks the frame map and the pool registers; predicts the reply to every accepted
  // request and compares the replies in order
  class frame_map_scoreboard;
    frame_t pool_base;
    cnt_t pool_frames;
    bit reserve_first;
    fstate_t frame_map [POOL_CAP];
    alloc_reply_t expected_replies [$];
    int mismatches;

    function new();
      pool_base = '0;
      pool_frames = RESET_FRAMES;
      reserve_first = 1'b0;
      mismatches = 0;
      rebuild_map();
    endfunction

    function int unsigned pool_size();
      return (pool_frames < POOL_CAP) ? pool_frames : POOL_CAP;
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction

    // every write to a defined register starts the pool over, as after reset
    function void rebuild_map();
      foreach (frame_map[i]) frame_map[i] = FS_FREE;
      if (reserve_first && pool_size() > 0) frame_map[0] = FS_USED;
    endfunction

    function void write_register(cfg_idx_t idx, cfg_data_t data);
      case (idx)
        CFG_POOL_BASE: pool_base = data;
        CFG_POOL_FRAMES: pool_frames = data[CNT_W-1:0];
        CFG_RESERVE_FIRST: reserve_first = data[0];
        default: return;
      endcase
      rebuild_map();
    endfunction

    // head first, the rest used; whatever was there is overwritten
    function void claim_run(int unsigned head, int unsigned len);
      for (int unsigned i = 0; i < len; i++)
        frame_map[head + i] = (i == 0) ? FS_HEAD : FS_USED;
    endfunction

    // random head of a live run, if any
    function bit pick_head(output int unsigned rel);
      int unsigned n, start;
      n = pool_size();
      rel = 0;
      if (n == 0) return 1'b0;
      start = $urandom_range(0, n - 1);
      for (int unsigned k = 0; k < n; k++) begin
        rel = (start + k) % n;
        if (frame_map[rel] == FS_HEAD) return 1'b1;
      end
      return 1'b0;
    endfunction

    function void note_request(op_t op, frame_t fno, cnt_t cnt);
      alloc_reply_t r;
      int unsigned n, run, rel, idx, freed;
      r = '0;
      n = pool_size();
      case (op)
        OP_ALLOC: begin
          if (cnt == 0) begin
            r.status = RS_BAD;
          end else begin
            // first fit over the whole pool
            r.status = RS_NO_RUN;
            run = 0;
            for (int unsigned i = 0; i < n; i++) begin
              if (frame_map[i] != FS_FREE) begin
                run = 0;
              end else begin
                run++;
                if (run == cnt) begin
                  claim_run(i + 1 - cnt, cnt);
                  r.status = RS_OK;
                  r.first_frame = pool_base + frame_t'(i + 1 - cnt);
                  break;
                end
              end
            end
          end
        end
        OP_RELEASE: begin
          if (fno < pool_base || fno - pool_base >= n) begin
            r.status = RS_BAD;
          end else begin
            rel = fno - pool_base;
            if (frame_map[rel] != FS_HEAD) begin
              r.status = RS_NOT_HEAD;
            end else begin
              // head plus the used tail, stopping at the next head or free frame
              frame_map[rel] = FS_FREE;
              freed = 1;
              idx = rel + 1;
              while (idx < n && frame_map[idx] == FS_USED) begin
                frame_map[idx] = FS_FREE;
                freed++;
                idx++;
              end
              r.freed_count = cnt_t'(freed);
            end
          end
        end
        OP_MARK: begin
          if (cnt == 0 || fno < pool_base) begin
            r.status = RS_BAD;
          end else begin
            rel = fno - pool_base;
            if (rel >= n || cnt > n - rel) r.status = RS_BAD;
            else claim_run(rel, cnt);
          end
        end
        default: r.status = RS_BAD;
      endcase
      expected_replies.push_back(r);
    endfunction

    function void report(string field, int unsigned want, int unsigned got);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: reply %s mismatch: expected %0d, got %0d", $time, field, want, got);
    endfunction

    function void check_response(status_t status, frame_t first, cnt_t freed);
      alloc_reply_t want;
      if (expected_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: reply with no request outstanding: status %0d first %0d freed %0d",
                   $time, status, first, freed);
        return;
      end
      want = expected_replies.pop_front();
      if (status !== want.status) report("status", want.status, status);
      if (first !== want.first_frame) report("first_frame", want.first_frame, first);
      if (freed !== want.freed_count) report("freed_count", want.freed_count, freed);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  cfa_cfg_if cfg_ch ();
  cfa_req_if req_ch ();
  cfa_rsp_if rsp_ch ();

  contiguous_frame_allocator_unit #(
    .MAX_FRAMES(POOL_CAP)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cfg(cfg_ch),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  frame_map_scoreboard sb;

  // no-idle stretch counters, one per side
  int req_quiet = 0;
  int rsp_quiet = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // idle cycles before the next handshake; now and then a stretch with none
  function automatic int draw_gap(inout int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      quiet = $urandom_range(8, 30);
      return 0;
    end
    return $urandom_range(0, 8);
  endfunction

  // one request; valid stays up after acceptance until the next call decides
  task automatic send_request(op_t op, frame_t fno, cnt_t cnt);
    int gap;
    gap = draw_gap(req_quiet);
    if (gap > 0) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_ch.valid <= 1'b1;
    req_ch.op <= op;
    req_ch.frame_no <= fno;
    req_ch.count <= cnt;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    sb.note_request(op, fno, cnt);
  endtask

  // mostly well-formed traffic: sized allocations, releases of live heads, marks inside
  // the pool; the rest zero counts, stray frame numbers, oversized runs and the unused op
  task automatic send_random_item();
    int unsigned n, rel, pick, lim;
    op_t op;
    frame_t fno;
    cnt_t cnt;
    n = sb.pool_size();
    pick = $urandom_range(0, 99);
    fno = frame_t'($urandom);
    cnt = cnt_t'($urandom);
    if (pick < 40) begin
      op = OP_ALLOC;
      if (pick < 2) begin
        cnt = '0;
      end else if (pick >= 4 && n > 0) begin
        lim = (pick < 8) ? n : (n + 3) / 4;
        cnt = cnt_t'($urandom_range(1, lim));
      end
    end else if (pick < 75) begin
      op = OP_RELEASE;
      if (pick < 68 && sb.pick_head(rel))
        fno = sb.pool_base + frame_t'(rel);
      else if (pick < 72 && n > 0)
        fno = sb.pool_base + frame_t'($urandom_range(0, n - 1));
    end else if (pick < 96) begin
      op = OP_MARK;
      if (pick < 91 && n > 0) begin
        rel = $urandom_range(0, n - 1);
        lim = (n - rel < 8) ? n - rel : 8;
        fno = sb.pool_base + frame_t'(rel);
        cnt = cnt_t'($urandom_range(1, lim));
      end
    end else begin
      op = OP_UNDEF;
    end
    send_request(op, fno, cnt);
  endtask

  task automatic send_random(int items);
    repeat (items) send_random_item();
  endtask

  // stop requesting and let every outstanding reply come back
  task automatic drain();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // register write, only ever issued with no reply outstanding
  task automatic write_register(cfg_idx_t idx, cfg_data_t data);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    sb.write_register(idx, data);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // response side: random stalls, check every accepted reply
  initial begin : reply_sink
    int gap;
    wait (rst == 1'b0);
    forever begin
      gap = draw_gap(rsp_quiet);
      if (gap > 0) begin
        @(negedge clk);
        rsp_ch.ready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk);
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (rsp_ch.valid !== 1'b1);
      sb.check_response(rsp_ch.status, rsp_ch.first_frame, rsp_ch.freed_count);
    end
  end

  // hard stop in case the allocator hangs
  initial begin
    #4000000;
    $display("contiguous_frame_allocator_unit test failed");
    $finish;
  end

  initial begin
    sb = new();
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_POOL_BASE;
    cfg_ch.data = '0;
    req_ch.valid = 1'b0;
    req_ch.op = OP_ALLOC;
    req_ch.frame_no = '0;
    req_ch.count = '0;
    rsp_ch.ready = 1'b0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed, reset pool: base 0, 1024 frames, nothing reserved
    send_request(OP_ALLOC, 20'd0, 11'd0);          // zero count
    send_request(OP_MARK, 20'd0, 11'd0);           // zero count
    send_request(OP_UNDEF, 20'hFFFFF, 11'h7FF);    // unused op
    send_request(OP_ALLOC, 20'd0, 11'd1024);       // whole pool
    send_request(OP_ALLOC, 20'd0, 11'd1);          // pool full
    send_request(OP_RELEASE, 20'd5, 11'd0);        // not a head
    send_request(OP_RELEASE, 20'd0, 11'd0);        // frees all 1024
    send_request(OP_ALLOC, 20'd0, 11'h7FF);        // longer than the pool
    send_request(OP_ALLOC, 20'd0, 11'd3);
    send_request(OP_ALLOC, 20'd0, 11'd2);
    send_request(OP_MARK, 20'd1, 11'd1);           // mark over an allocated run
    send_request(OP_RELEASE, 20'd0, 11'd0);        // stops at the new head
    send_request(OP_RELEASE, 20'd1, 11'd0);
    send_request(OP_RELEASE, 20'd3, 11'd0);
    send_request(OP_RELEASE, 20'd1024, 11'd0);     // just past the pool
    send_request(OP_RELEASE, 20'hFFFFF, 11'd0);    // far out of range
    send_request(OP_MARK, 20'd1023, 11'd1);        // last frame
    send_request(OP_MARK, 20'd1023, 11'd2);        // runs off the end
    send_request(OP_MARK, 20'hFFFFF, 11'd1);
    send_request(OP_ALLOC, 20'd0, 11'd1023);
    send_request(OP_RELEASE, 20'd1023, 11'd0);
    send_request(OP_RELEASE, 20'd0, 11'd0);
    send_request(OP_MARK, 20'd0, 11'd1024);        // mark the whole pool
    send_request(OP_RELEASE, 20'd0, 11'd0);
    drain();

    // small pool, first frame reserved; stray upper data bits on the frame count
    write_register(CFG_POOL_BASE, 20'h12345);
    write_register(CFG_POOL_FRAMES, {9'h1A5, 11'd16});
    write_register(CFG_RESERVE_FIRST, 20'd1);
    send_random(70);
    drain();

    // unused index leaves the pool alone
    write_register(CFG_UNUSED, cfg_data_t'($urandom));
    send_random(30);
    drain();

    // empty pool
    write_register(CFG_POOL_FRAMES, 20'd0);
    send_random(15);
    drain();

    // single frame, reserved, then free
    write_register(CFG_POOL_BASE, 20'd0);
    write_register(CFG_POOL_FRAMES, 20'd1);
    send_random(15);
    drain();
    write_register(CFG_RESERVE_FIRST, 20'd0);
    send_random(20);
    drain();

    // top of the frame space: first_frame wraps, most frames unreachable by number
    write_register(CFG_POOL_BASE, 20'hFFFFF);
    write_register(CFG_POOL_FRAMES, 20'd8);
    send_random(25);
    drain();

    // frame count above the map depth, clipped to the full map
    write_register(CFG_POOL_BASE, 20'h00400);
    write_register(CFG_POOL_FRAMES, 20'd2047);
    write_register(CFG_RESERVE_FIRST, 20'd1);
    send_random(60);
    drain();

    // bulk of the random traffic on a mid-sized pool
    write_register(CFG_POOL_BASE, 20'h80000);
    write_register(CFG_POOL_FRAMES, 20'd32);
    write_register(CFG_RESERVE_FIRST, 20'd0);
    send_random(150);
    drain();

    write_register(CFG_POOL_BASE, 20'h00007);
    write_register(CFG_POOL_FRAMES, 20'd3);
    send_random(40);
    drain();

    // anything arriving now is a stray reply
    repeat (2 * POOL_CAP + 16) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("contiguous_frame_allocator_unit test passed");
    end else begin
      $display("contiguous_frame_allocator_unit test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
